// File: hdl/esmt_pkg.sv
// Package for the event subscription match table: sizes, types and key building.
// Depends on nothing; used by every module in hdl.
`default_nettype none
package esmt_pkg;
	localparam int TableEntries = 512;
	localparam int SlotW = $clog2(TableEntries);
	localparam int CntW = SlotW + 1;

	typedef enum logic [1:0] {
		FUNC_SUB   = 2'd0,
		FUNC_UNSUB = 2'd1,
		FUNC_PUB   = 2'd2,
		FUNC_HAS   = 2'd3
	} func_t;

	localparam logic [2:0] TYPE_NONE = 3'd0;
	localparam logic [2:0] TYPE_HYPERCALL = 3'd1;
	localparam logic [2:0] TYPE_EXCEPTION = 3'd2;
	localparam logic [2:0] TYPE_IO = 3'd3;
	localparam logic [2:0] TYPE_CR = 3'd4;
	localparam logic [2:0] TYPE_HALT = 3'd5;

	// Request broadcast to every cell during a scan.
	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  etype;
		logic [31:0] key;
		logic [15:0] handler;
		logic [9:0]  start;
		logic        scan;
	} req_t;

	// Per-cell answers to the current request.
	typedef struct packed {
		logic        hit;
		logic [15:0] handler;
		logic        excp;
		logic [4:0]  vec;
	} resp_t;

	function automatic logic [31:0] make_key(input logic [2:0] t, input logic [31:0] hc,
		input logic [4:0] ex, input logic dir, input logic [15:0] port,
		input logic [3:0] cr, input logic wr);
		logic [31:0] k;
		case (t)
			TYPE_HYPERCALL: k = hc;
			TYPE_EXCEPTION: k = {27'd0, ex};
			TYPE_IO:        k = {15'd0, dir, port};
			TYPE_CR:        k = {27'd0, wr, cr};
			default:        k = 32'd0;
		endcase
		return k;
	endfunction
endpackage
`default_nettype wire

// File: hdl/esmt_cell.sv
// One table slot: stored type, condition key and handler, with its match logic.
// Depends on esmt_pkg.
`default_nettype none
module esmt_cell import esmt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [SlotW-1:0] idx,
	input  wire req_t             req,
	input  wire logic             wr_en,
	input  wire logic             clr_en,
	output resp_t                 resp
);
	logic [2:0]  type_q;
	logic [31:0] cond_q;
	logic [15:0] hnd_q;
	logic        eq;

	assign eq = (type_q == req.etype);

	// Match rule for the pending function.
	always_comb begin
		resp.handler = hnd_q;
		resp.excp = (type_q == TYPE_EXCEPTION);
		resp.vec = cond_q[4:0];
		case (func_t'(req.func))
			FUNC_SUB:   resp.hit = (type_q == TYPE_NONE);
			FUNC_UNSUB: resp.hit = eq && cond_q == req.key;
			FUNC_PUB:   resp.hit = eq && ({1'b0, idx} >= req.start) &&
				(req.etype == TYPE_HALT ||
				(req.etype != TYPE_NONE && cond_q == req.key));
			FUNC_HAS:   resp.hit = eq;
			default:    resp.hit = 1'b0;
		endcase
	end

	// Type is control state; key and handler are payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= TYPE_NONE;
		end else if (wr_en) begin
			type_q <= req.etype;
		end else if (clr_en) begin
			type_q <= TYPE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cond_q <= req.key;
			hnd_q <= req.handler;
		end
	end
endmodule
`default_nettype wire

// File: hdl/event_subscription_match_table_unit.sv
// Top level of the event subscription match table: cell row, slot scanner, bitmap.
// Depends on esmt_pkg and esmt_cell.
//
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | func, event kind, hypercall_number, exception_number, io_direction,
//          |     | port_number, cr_number, cr_is_write, handler_id, start_slot (89 bits)
//  m_axis  | out | ok, slot, matched_handler, exception_bitmap (58 bits)
//
// The scan pointer reads one cell a cycle into a registered stage, from start_slot for
// publish and slot 0 otherwise; a hit ends the scan, else it ends past the last slot.
// The result is then held until m_axis_tready; the input is ready again in the cycle
// after the result item leaves. Reset frees every slot and clears the counts.
// A held result stalls the next item's acceptance; the input waits during a scan.
`default_nettype none
module event_subscription_match_table_unit import esmt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata, // func, event kind, hypercall_number,
	                                       // exception_number, io_direction, port_number,
	                                       // cr_number, cr_is_write, handler_id, start_slot
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata  // ok, slot, matched_handler, exception_bitmap
);
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} state_t;
	state_t state_q;
	req_t req_q;
	logic [CntW-1:0] ptr_q;
	logic [CntW-1:0] cnt_q [32];
	resp_t resp [TableEntries];
	logic [TableEntries-1:0] wr_v, clr_v;
	logic ok_q;
	logic [SlotW-1:0] slot_q;
	logic [15:0] hnd_q;
	logic [31:0] bmap;
	resp_t cur_s1;
	logic [CntW-1:0] ptr_s1;
	logic v_s1;
	logic etype_ok, fire, done;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign etype_ok = (req_q.etype <= TYPE_HALT);
	assign fire = (state_q == ST_SCAN) && v_s1 && !ptr_s1[SlotW] && cur_s1.hit && etype_ok &&
		!(req_q.func == FUNC_UNSUB && req_q.etype == TYPE_NONE);
	assign done = (state_q == ST_SCAN) && v_s1 && ptr_s1[SlotW];

	genvar g;
	generate
		for (g = 0; g < TableEntries; g++) begin : g_cell
			assign wr_v[g] = fire && ptr_s1[SlotW-1:0] == SlotW'(g) &&
				req_q.func == FUNC_SUB && req_q.etype != TYPE_NONE;
			assign clr_v[g] = fire && ptr_s1[SlotW-1:0] == SlotW'(g) &&
				req_q.func == FUNC_UNSUB;
			esmt_cell u_cell (.clk(clk), .arst_n(arst_n), .idx(SlotW'(g)), .req(req_q),
				.wr_en(wr_v[g]), .clr_en(clr_v[g]), .resp(resp[g]));
		end
		for (g = 0; g < 32; g++) begin : g_bm
			assign bmap[g] = (cnt_q[g] != '0);
		end
	endgenerate

	assign m_axis_tdata = {6'd0, bmap, hnd_q, slot_q, ok_q};

	// Sequencer: accept, scan one slot a cycle through a registered stage, hold result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q <= '0;
			ptr_s1 <= '0;
			cur_s1 <= '0;
			v_s1 <= 1'b0;
			ok_q <= 1'b0;
			slot_q <= '0;
			hnd_q <= '0;
			req_q.scan <= 1'b0;
			for (int i = 0; i < 32; i++) cnt_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					req_q.func <= s_axis_tdata[1:0];
					req_q.etype <= s_axis_tdata[4:2];
					req_q.key <= make_key(s_axis_tdata[4:2], s_axis_tdata[36:5],
						s_axis_tdata[41:37], s_axis_tdata[42], s_axis_tdata[58:43],
						s_axis_tdata[62:59], s_axis_tdata[63]);
					req_q.handler <= s_axis_tdata[79:64];
					req_q.start <= {1'b0, s_axis_tdata[88:80]};
					req_q.scan <= 1'b1;
					ptr_q <= (s_axis_tdata[1:0] == FUNC_PUB) ?
						{1'b0, s_axis_tdata[88:80]} : '0;
					v_s1 <= 1'b0;
					ok_q <= 1'b0;
					slot_q <= '0;
					hnd_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// Read the cell under the pointer; the decision uses the previous read.
					cur_s1 <= resp[ptr_q[SlotW-1:0]];
					ptr_s1 <= ptr_q;
					v_s1 <= !(fire || done);
					if (!ptr_q[SlotW]) ptr_q <= ptr_q + 1'b1;
					if (fire) begin
						ok_q <= 1'b1;
						slot_q <= ptr_s1[SlotW-1:0];
						if (req_q.func == FUNC_PUB) hnd_q <= cur_s1.handler;
						if (req_q.func == FUNC_SUB && req_q.etype == TYPE_EXCEPTION)
							cnt_q[req_q.key[4:0]] <= cnt_q[req_q.key[4:0]] + 1'b1;
						if (req_q.func == FUNC_UNSUB && req_q.etype == TYPE_EXCEPTION &&
							cnt_q[req_q.key[4:0]] != '0)
							cnt_q[req_q.key[4:0]] <= cnt_q[req_q.key[4:0]] - 1'b1;
						req_q.scan <= 1'b0;
						state_q <= ST_OUT;
					end else if (done) begin
						req_q.scan <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: test/event_subscription_match_table_unit_test.sv
// Self-checking testbench for the event subscription match table unit.
// Depends on esmt_pkg and the RTL in hdl; it predicts every result item in its own table copy.
`timescale 1ns / 1ps

module event_subscription_match_table_unit_test;
	import esmt_pkg::*;

	typedef struct {
		func_t       func;
		logic [2:0]  etype;
		logic [31:0] hc_num;
		logic [4:0]  exc_num;
		logic        io_dir;
		logic [15:0] port;
		logic [3:0]  cr_num;
		logic        cr_wr;
		logic [15:0] handler;
		logic [8:0]  start;
	} request_t;

	typedef struct {
		logic        ok;
		logic [8:0]  slot;
		logic [15:0] handler;
		logic [31:0] bitmap;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;

	event_subscription_match_table_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of the subscription table.
	logic [2:0]  shadow_type [TableEntries];
	logic [31:0] shadow_key [TableEntries];
	logic [15:0] shadow_handler [TableEntries];
	int          exc_subscribers [32];

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	request_t current_request;
	int       fail_count = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	logic     accepted = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Condition key of a request, by event type.
	function automatic logic [31:0] condition_key(request_t r);
		case (r.etype)
			TYPE_HYPERCALL: return r.hc_num;
			TYPE_EXCEPTION: return {27'd0, r.exc_num};
			TYPE_IO:        return {15'd0, r.io_dir, r.port};
			TYPE_CR:        return {27'd0, r.cr_wr, r.cr_num};
			default:        return 32'd0;
		endcase
	endfunction

	// Applies one request to the shadow table and returns the answer it causes.
	function automatic answer_t apply_request(request_t r);
		answer_t a;
		logic [31:0] key;
		key = condition_key(r);
		a = '{1'b0, 9'd0, 16'd0, 32'd0};
		case (r.func)
			FUNC_SUB: begin
				if (r.etype <= TYPE_HALT) begin
					for (int i = 0; i < TableEntries; i++) begin
						if (shadow_type[i] == TYPE_NONE) begin
							a.ok = 1'b1;
							a.slot = i[8:0];
							if (r.etype != TYPE_NONE) begin
								shadow_type[i] = r.etype;
								shadow_key[i] = key;
								shadow_handler[i] = r.handler;
								if (r.etype == TYPE_EXCEPTION)
									exc_subscribers[key[4:0]]++;
							end
							break;
						end
					end
				end
			end
			FUNC_UNSUB: begin
				if (r.etype != TYPE_NONE && r.etype <= TYPE_HALT) begin
					for (int i = 0; i < TableEntries; i++) begin
						if (shadow_type[i] == r.etype && shadow_key[i] == key) begin
							a.ok = 1'b1;
							a.slot = i[8:0];
							shadow_type[i] = TYPE_NONE;
							if (r.etype == TYPE_EXCEPTION && exc_subscribers[key[4:0]] != 0)
								exc_subscribers[key[4:0]]--;
							break;
						end
					end
				end
			end
			FUNC_PUB: begin
				// Halt matches any halt slot; none and undefined types never match.
				if (r.etype != TYPE_NONE && r.etype <= TYPE_HALT) begin
					for (int i = r.start; i < TableEntries; i++) begin
						if (shadow_type[i] == r.etype &&
								(r.etype == TYPE_HALT || shadow_key[i] == key)) begin
							a.ok = 1'b1;
							a.slot = i[8:0];
							a.handler = shadow_handler[i];
							break;
						end
					end
				end
			end
			default: begin
				for (int i = 0; i < TableEntries; i++) begin
					if (shadow_type[i] == r.etype) begin
						a.ok = 1'b1;
						a.slot = i[8:0];
						break;
					end
				end
			end
		endcase
		for (int n = 0; n < 32; n++)
			a.bitmap[n] = (exc_subscribers[n] != 0);
		return a;
	endfunction

	function automatic request_t make_request(func_t f, logic [2:0] t, logic [31:0] hc,
		logic [4:0] ex, logic dir, logic [15:0] port, logic [3:0] cr, logic wr,
		logic [15:0] h, logic [8:0] st);
		request_t r;
		r = '{f, t, hc, ex, dir, port, cr, wr, h, st};
		return r;
	endfunction

	// Random request; keys come mostly from small pools so that lookups hit.
	function automatic request_t random_request(int sub_w, int unsub_w, int pub_w);
		request_t r;
		int roll;
		roll = $urandom_range(99);
		if (roll < sub_w)
			r.func = FUNC_SUB;
		else if (roll < sub_w + unsub_w)
			r.func = FUNC_UNSUB;
		else if (roll < sub_w + unsub_w + pub_w)
			r.func = FUNC_PUB;
		else
			r.func = FUNC_HAS;
		roll = $urandom_range(99);
		if (roll < 4)
			r.etype = TYPE_NONE;
		else if (roll < 7)
			r.etype = 3'($urandom_range(7, 6));
		else
			r.etype = 3'($urandom_range(TYPE_HALT, TYPE_HYPERCALL));
		case ($urandom_range(3))
			0: r.hc_num = 32'hFFFF_FFFF;
			1: r.hc_num = $urandom;
			default: r.hc_num = 32'($urandom_range(3));
		endcase
		r.exc_num = 5'($urandom);
		r.io_dir = 1'($urandom);
		case ($urandom_range(3))
			0: r.port = 16'hFFFF;
			1: r.port = 16'($urandom);
			default: r.port = 16'($urandom_range(3));
		endcase
		r.cr_num = 4'($urandom);
		r.cr_wr = 1'($urandom);
		r.handler = 16'($urandom);
		case ($urandom_range(3))
			0: r.start = 9'($urandom);
			1: r.start = 9'($urandom_range(15));
			default: r.start = 9'd0;
		endcase
		return r;
	endfunction

	// Driver: offers the next pending item at the falling edge.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (accepted || !s_axis_tvalid) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				current_request = pending_requests.pop_front();
				s_axis_tdata <= {7'd0, current_request.start, current_request.handler,
					current_request.cr_wr, current_request.cr_num, current_request.port,
					current_request.io_dir, current_request.exc_num, current_request.hc_num,
					current_request.etype, current_request.func};
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each accepted request and checks each result item.
	always @(posedge clk) begin
		answer_t want;
		answer_t got;
		accepted <= s_axis_tvalid && s_axis_tready && arst_n;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_answers.push_back(apply_request(current_request));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[0], m_axis_tdata[9:1], m_axis_tdata[25:10],
				m_axis_tdata[57:26]};
			if (expected_answers.size() == 0) begin
				$error("unexpected result item %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_answers.pop_front();
				if (got.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, got.ok);
					fail_count++;
				end
				if (got.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, got.slot);
					fail_count++;
				end
				if (got.handler !== want.handler) begin
					$error("matched_handler: expected %h, got %h", want.handler, got.handler);
					fail_count++;
				end
				if (got.bitmap !== want.bitmap) begin
					$error("exception_bitmap: expected %h, got %h", want.bitmap, got.bitmap);
					fail_count++;
				end
			end
		end
	end

	task automatic wait_until_drained();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus: directed cases, then four phases with different idling.
	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		arst_n = 1'b0;
		for (int i = 0; i < TableEntries; i++) begin
			shadow_type[i] = TYPE_NONE;
			shadow_key[i] = '0;
			shadow_handler[i] = '0;
		end
		for (int n = 0; n < 32; n++)
			exc_subscribers[n] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every type and function, field extremes and the corner cases.
		pending_requests.push_back(make_request(FUNC_HAS, TYPE_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_SUB, TYPE_NONE, 0, 0, 0, 0, 0, 0, 16'h1, 0));
		pending_requests.push_back(make_request(FUNC_SUB, TYPE_HYPERCALL, 32'hFFFF_FFFF,
			0, 0, 0, 0, 0, 16'hFFFF, 0));
		pending_requests.push_back(make_request(FUNC_SUB, TYPE_EXCEPTION, 0, 5'd31,
			0, 0, 0, 0, 16'h0000, 0));
		pending_requests.push_back(make_request(FUNC_SUB, TYPE_EXCEPTION, 0, 5'd0,
			0, 0, 0, 0, 16'h1234, 0));
		pending_requests.push_back(make_request(FUNC_SUB, TYPE_IO, 0, 0, 1'b1, 16'hFFFF,
			0, 0, 16'h5555, 0));
		pending_requests.push_back(make_request(FUNC_SUB, TYPE_CR, 0, 0, 0, 0, 4'hF, 1'b1,
			16'hAAAA, 0));
		pending_requests.push_back(make_request(FUNC_SUB, TYPE_HALT, 0, 0, 0, 0, 0, 0, 16'h7, 0));
		pending_requests.push_back(make_request(FUNC_SUB, 3'd7, 0, 0, 0, 0, 0, 0, 16'h9, 0));
		pending_requests.push_back(make_request(FUNC_PUB, TYPE_HYPERCALL, 32'hFFFF_FFFF,
			0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_PUB, TYPE_EXCEPTION, 0, 5'd31,
			0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_PUB, TYPE_IO, 0, 0, 1'b1, 16'hFFFF,
			0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_PUB, TYPE_CR, 0, 0, 0, 0, 4'hF, 1'b1,
			0, 9'd5));
		pending_requests.push_back(make_request(FUNC_PUB, TYPE_HALT, 0, 0, 0, 0, 0, 0, 0, 9'd6));
		pending_requests.push_back(make_request(FUNC_PUB, TYPE_HALT, 0, 0, 0, 0, 0, 0, 0, 9'd511));
		pending_requests.push_back(make_request(FUNC_PUB, TYPE_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_PUB, 3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_HAS, TYPE_CR, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_HAS, 3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_UNSUB, TYPE_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_UNSUB, 3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_UNSUB, TYPE_HALT, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_UNSUB, TYPE_EXCEPTION, 0, 5'd31,
			0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(FUNC_UNSUB, TYPE_IO, 0, 0, 1'b0, 16'hFFFF,
			0, 0, 0, 0));

		// Mixed traffic with no idling.
		for (int k = 0; k < 275; k++)
			pending_requests.push_back(random_request(35, 20, 30));
		wait_until_drained();

		// Mostly subscribes with the sender idle, enough to fill the table.
		send_idle_pct = 79;
		for (int k = 0; k < 560; k++)
			pending_requests.push_back(random_request(97, 1, 1));
		wait_until_drained();

		// Lookups on a full table with the receiver stalling.
		send_idle_pct = 0;
		recv_stall_pct = 79;
		for (int k = 0; k < 150; k++)
			pending_requests.push_back(random_request(10, 20, 45));
		wait_until_drained();

		// Mostly unsubscribes with both sides idling.
		send_idle_pct = 15;
		recv_stall_pct = 15;
		for (int k = 0; k < 150; k++)
			pending_requests.push_back(random_request(10, 60, 20));
		wait_until_drained();

		repeat (600) @(posedge clk);
		if (fail_count == 0 && expected_answers.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#30ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// File: filelist.f
hdl/esmt_pkg.sv
hdl/esmt_cell.sv
hdl/event_subscription_match_table_unit.sv
test/event_subscription_match_table_unit_test.sv
